// ----- src/lbps_pkg.sv -----
// lbps_pkg: shared types, command codes and blink pattern tables for the
// LED blink pattern sequencer. No dependencies.

package lbps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_SET_PATTERN = 2'd1,
    CMD_SET_ENABLE  = 2'd2,
    CMD_SET_LOOP    = 2'd3
  } cmd_e;

  localparam int unsigned TableRows  = 16;
  localparam int unsigned TableSteps = 8;
  localparam int unsigned MsWidth    = 12;

  // Per-LED control, broadcast from the top level to every LED unit.
  typedef struct packed {
    logic       apply;       // item moves to the result register this cycle
    cmd_e       cmd;
    logic       sel;         // this LED is addressed (index valid)
    logic [3:0] pattern;
    logic       pattern_ok;  // pattern number in range
    logic       flag;
  } led_ctrl_t;

  // Per-LED status as it stands once the current item has taken effect.
  typedef struct packed {
    logic       level;
    logic       enabled;
    logic [3:0] running;
    logic [2:0] step;
  } led_stat_t;

  // Step durations in ms; a zero duration ends the pattern.
  localparam logic [MsWidth-1:0] StepMs [TableRows][TableSteps] = '{
    '{12'd100,  12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd100,  12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd900,  12'd100, 12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd700,  12'd110, 12'd80,  12'd110, 12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd300,  12'd100, 12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd25,   12'd25,  12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{12'd2000, 12'd500, 12'd100, 12'd3000, 12'd0,  12'd0,   12'd0,   12'd0},
    '{12'd2000, 12'd500, 12'd100, 12'd500, 12'd100, 12'd3000, 12'd0,  12'd0},
    '{12'd2000, 12'd500, 12'd100, 12'd500, 12'd100, 12'd500, 12'd100, 12'd3000},
    '{12'd2000, 12'd3000, 12'd0,  12'd0,   12'd0,   12'd0,   12'd0,   12'd0},
    '{default: 12'd0},
    '{default: 12'd0},
    '{default: 12'd0},
    '{default: 12'd0},
    '{default: 12'd0},
    '{default: 12'd0}
  };

  // Step levels, bit s is the LED level during step s.
  localparam logic [TableSteps-1:0] StepLevel [TableRows] = '{
    8'b0000_0000,
    8'b0000_0001,
    8'b0000_0010,
    8'b0000_1010,
    8'b0000_0010,
    8'b0000_0001,
    8'b0000_0101,
    8'b0001_0101,
    8'b0101_0101,
    8'b0000_0001,
    8'b0000_0000,
    8'b0000_0000,
    8'b0000_0000,
    8'b0000_0000,
    8'b0000_0000,
    8'b0000_0000
  };

endpackage

// ----- src/lbps_if.sv -----
// lbps_in_if / lbps_out_if: valid/ready channels of the LED blink pattern
// sequencer. Depends on nothing.

interface lbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] led_index;
  logic [3:0] pattern;
  logic       flag;

  modport source (output valid, cmd, led_index, pattern, flag, input ready);
  modport sink   (input valid, cmd, led_index, pattern, flag, output ready);
endinterface

interface lbps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] led_levels;
  logic [1:0] enabled_mask;
  logic [3:0] current_pattern;
  logic [2:0] current_step;
  logic       ok;

  modport source (output valid, led_levels, enabled_mask, current_pattern,
                  current_step, ok, input ready);
  modport sink   (input valid, led_levels, enabled_mask, current_pattern,
                  current_step, ok, output ready);
endinterface

// ----- src/lbps_led_unit.sv -----
// lbps_led_unit: state and per-beat update of one LED's blink sequencer.
// Depends on lbps_pkg.

module lbps_led_unit #(
  parameter int unsigned MAX_STEPS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lbps_pkg::led_ctrl_t   ctrl_i,
  output lbps_pkg::led_stat_t   stat_o
);

  localparam logic [3:0] MaxSteps = 4'(MAX_STEPS);

  logic [3:0]                     pending_q, pending_d;
  logic [3:0]                     running_q, running_d;
  logic [2:0]                     step_q, step_d;
  logic [lbps_pkg::MsWidth-1:0]   rem_q, rem_d;
  logic                           en_q, en_d;
  logic                           loop_q, loop_d;
  logic                           level_q, level_d;

  // tick datapath
  logic                           restart;
  logic [2:0]                     step_a;
  logic [lbps_pkg::MsWidth-1:0]   rem_a, rem_b;
  logic                           level_a;
  logic [3:0]                     nxt;
  logic                           nxt_ok;
  logic [2:0]                     step_c;
  logic                           en_c;

  always_comb begin
    restart = (pending_q != running_q);
    step_a  = restart ? 3'd0 : step_q;
    rem_a   = restart ? lbps_pkg::StepMs[pending_q][0] : rem_q;
    level_a = restart ? lbps_pkg::StepLevel[pending_q][0] : level_q;
    rem_b   = (rem_a != '0) ? rem_a - 1'b1 : rem_a;

    nxt    = {1'b0, step_a} + 4'd1;
    nxt_ok = (nxt < MaxSteps) && (lbps_pkg::StepMs[pending_q][nxt[2:0]] != '0);
    if (nxt_ok) begin
      step_c = nxt[2:0];
      en_c   = 1'b1;
    end else if (loop_q) begin
      step_c = 3'd0;
      en_c   = 1'b1;
    end else begin
      step_c = step_a;
      en_c   = 1'b0;
    end
  end

  always_comb begin
    pending_d = pending_q;
    running_d = running_q;
    step_d    = step_q;
    rem_d     = rem_q;
    en_d      = en_q;
    loop_d    = loop_q;
    level_d   = level_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.cmd)
        lbps_pkg::CMD_TICK: begin
          if (en_q) begin
            running_d = pending_q;
            if (rem_b == '0) begin
              step_d  = step_c;
              en_d    = en_c;
              rem_d   = lbps_pkg::StepMs[pending_q][step_c];
              level_d = lbps_pkg::StepLevel[pending_q][step_c];
            end else begin
              step_d  = step_a;
              rem_d   = rem_b;
              level_d = level_a;
            end
          end
        end
        lbps_pkg::CMD_SET_PATTERN: begin
          if (ctrl_i.sel && ctrl_i.pattern_ok) pending_d = ctrl_i.pattern;
        end
        lbps_pkg::CMD_SET_ENABLE: begin
          if (ctrl_i.sel) en_d = ctrl_i.flag;
        end
        lbps_pkg::CMD_SET_LOOP: begin
          if (ctrl_i.sel) loop_d = ctrl_i.flag;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      running_q <= '0;
      step_q    <= '0;
      rem_q     <= '0;
      en_q      <= 1'b0;
      loop_q    <= 1'b0;
      level_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      running_q <= running_d;
      step_q    <= step_d;
      rem_q     <= rem_d;
      en_q      <= en_d;
      loop_q    <= loop_d;
      level_q   <= level_d;
    end
  end

  // status after this beat takes effect
  assign stat_o.level   = level_d;
  assign stat_o.enabled = en_d;
  assign stat_o.running = running_d;
  assign stat_o.step    = step_d;

endmodule

// ----- src/led_blink_pattern_sequencer_core.sv -----
// led_blink_pattern_sequencer_core: top level of the LED blink pattern
// sequencer. Depends on lbps_pkg, lbps_if.sv and lbps_led_unit.
//
// Usage:
//   in_i  (sink) carries one command per beat: cmd selects a 1 ms tick, set
//         pattern, set enable or set loop; led_index, pattern and flag are
//         the operands. Ticks advance every enabled LED at once.
//   out_o (source) returns exactly one result beat per command: the level
//         and enable bits of LEDs 0 and 1, the running pattern and step of
//         the addressed LED, and ok (index and, for set pattern, pattern in
//         range). All fields show the state after the command took effect.
//   Path: each command passes the input register, then the result register,
//         where its result beat is held until out_o takes it.
//   Throughput: one beat per cycle while out_o is not held; every LED unit
//         updates in parallel between the two registers.
//   Stall: while out_o is held, one more command waits in the input
//         register, then in_i.ready drops; nothing is lost or repeated.
//   Reset: all LEDs go to pattern 0, step 0, disabled, loop off, level off;
//         both registers empty. No warm-up time after reset.

module led_blink_pattern_sequencer_core #(
  parameter int unsigned NUM_LEDS     = 2,
  parameter int unsigned MAX_STEPS    = 8,
  parameter int unsigned NUM_PATTERNS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbps_in_if.sink       in_i,
  lbps_out_if.source    out_o
);

  localparam int unsigned VisLeds     = (NUM_LEDS < 2) ? NUM_LEDS : 2;
  localparam logic [2:0]  NumLeds     = 3'(NUM_LEDS);
  localparam logic [4:0]  NumPatterns = 5'(NUM_PATTERNS);

  // ---- input register ----
  logic             in_vld_q;
  lbps_pkg::cmd_e   cmd_q;
  logic [1:0]       idx_q;
  logic [3:0]       pat_q;
  logic             flag_q;

  // ---- result register ----
  logic             out_vld_q, out_vld_d;
  logic [1:0]       levels_q, levels_d;
  logic [1:0]       enables_q, enables_d;
  logic [3:0]       cur_pat_q, cur_pat_d;
  logic [2:0]       cur_step_q, cur_step_d;
  logic             ok_q, ok_d;

  logic             out_free;   // result register can take a beat
  logic             move;       // held command is applied this cycle
  logic             led_ok;
  logic             pat_ok;

  lbps_pkg::led_ctrl_t  ctrl [NUM_LEDS];
  lbps_pkg::led_stat_t  stat [NUM_LEDS];

  assign out_free   = !out_vld_q || out_o.ready;
  assign move       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= lbps_pkg::cmd_e'(in_i.cmd);
      idx_q  <= in_i.led_index;
      pat_q  <= in_i.pattern;
      flag_q <= in_i.flag;
    end
  end

  assign led_ok = ({1'b0, idx_q} < NumLeds);
  assign pat_ok = ({1'b0, pat_q} < NumPatterns);

  // ---- LED units, one per LED, all updating in the same cycle ----
  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
    assign ctrl[g].apply      = move;
    assign ctrl[g].cmd        = cmd_q;
    assign ctrl[g].sel        = (idx_q == 2'(g));
    assign ctrl[g].pattern    = pat_q;
    assign ctrl[g].pattern_ok = pat_ok;
    assign ctrl[g].flag       = flag_q;

    lbps_led_unit #(
      .MAX_STEPS (MAX_STEPS)
    ) u_led (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .stat_o (stat[g])
    );
  end

  // ---- result assembly ----
  always_comb begin
    levels_d   = '0;
    enables_d  = '0;
    cur_pat_d  = '0;
    cur_step_d = '0;
    // only LEDs 0 and 1 fit the masks
    for (int i = 0; i < VisLeds; i++) begin
      levels_d[i]  = stat[i].level;
      enables_d[i] = stat[i].enabled;
    end
    // addressed LED; an out-of-range index matches no unit and reads zero
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (idx_q == 2'(i)) begin
        cur_pat_d  = stat[i].running;
        cur_step_d = stat[i].step;
      end
    end
    ok_d = led_ok;
    if (cmd_q == lbps_pkg::CMD_SET_PATTERN) ok_d = led_ok && pat_ok;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (move) out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      levels_q   <= levels_d;
      enables_q  <= enables_d;
      cur_pat_q  <= cur_pat_d;
      cur_step_q <= cur_step_d;
      ok_q       <= ok_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.led_levels      = levels_q;
  assign out_o.enabled_mask    = enables_q;
  assign out_o.current_pattern = cur_pat_q;
  assign out_o.current_step    = cur_step_q;
  assign out_o.ok              = ok_q;

endmodule

// ----- src/lbps_checker.sv -----
// lbps_checker: port-level assertions for led_blink_pattern_sequencer_core,
// attached by the bind below. Depends on the top level's ports only.

module lbps_checker #(
  parameter int unsigned MAX_STEPS    = 8,
  parameter int unsigned NUM_PATTERNS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] led_levels_i,
  input  logic [1:0] enabled_mask_i,
  input  logic [3:0] current_pattern_i,
  input  logic [2:0] current_step_i,
  input  logic       ok_i
);

  localparam logic [4:0] NumPatterns = 5'(NUM_PATTERNS);
  localparam logic [3:0] MaxSteps    = 4'(MAX_STEPS);

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(led_levels_i) && $stable(enabled_mask_i) && $stable(current_pattern_i)
      && $stable(current_step_i) && $stable(ok_i))
    else $error("result payload changed while stalled");

  // a running pattern is always one that set pattern accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, current_pattern_i} < NumPatterns))
    else $error("running pattern out of range");

  // step never runs past the pattern length limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, current_step_i} < MaxSteps))
    else $error("step index beyond limit");

endmodule

bind led_blink_pattern_sequencer_core lbps_checker #(
  .MAX_STEPS    (MAX_STEPS),
  .NUM_PATTERNS (NUM_PATTERNS)
) u_lbps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .led_levels_i      (out_o.led_levels),
  .enabled_mask_i    (out_o.enabled_mask),
  .current_pattern_i (out_o.current_pattern),
  .current_step_i    (out_o.current_step),
  .ok_i              (out_o.ok)
);
